/* rtl/glpd_pkg.sv */
// Shared types and constants for the grid local peak detector.
package glpd_pkg;

   localparam int CFG_DIM_W   = 11;
   localparam int ROW_W       = 10;
   localparam int COL_W       = 10;
   localparam int VALUE_W     = 16;
   localparam int TOTAL_W     = 19;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_DEPTH   = 4;
   localparam int MIN_DIM     = 3;

   localparam logic [TOTAL_W-1:0]   PEAK_TOTAL_MAX     = '1;
   localparam logic [CFG_DIM_W-1:0] GRID_COLUMNS_RESET = 11'd7;
   localparam logic [CFG_DIM_W-1:0] GRID_ROWS_RESET    = 11'd6;

   typedef enum logic {
      REPORT_PEAK  = 1'b0,
      REPORT_COUNT = 1'b1
   } report_kind_type;

   typedef enum logic {
      CSR_GRID_COLUMNS = 1'b0,
      CSR_GRID_ROWS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] grid_columns;
      logic [CFG_DIM_W-1:0] grid_rows;
   } cfg_type;

   typedef struct packed {
      report_kind_type     report_kind;
      logic [ROW_W-1:0]    peak_row;
      logic [COL_W-1:0]    peak_column;
      logic [VALUE_W-1:0]  peak_value;
      logic [TOTAL_W-1:0]  peak_total;
      logic                last_of_grid;
   } rsp_beat_type;

   typedef struct packed {
      logic         peak_valid;
      rsp_beat_type peak;
      logic         count_valid;
      rsp_beat_type count;
   } result_push_type;

endpackage

/* rtl/grid_local_peak_detect_core.sv */
// Top level of the grid local peak detector.
//
//   channel   direction  beat
//   req_      in         one grid sample, raster order
//   rsp_      out        one peak report or one end-of-grid count report
//   csr       in/out     grid_columns at 0x0, grid_rows at 0x4
//
// One sample per cycle while req_stall is low; its reports enter the result queue at the accepting edge.
// A report shows on rsp_ once it reaches the head of the result queue, behind any beats already queued.
// Line store reads are issued for the next column, so read data is ready when that sample arrives.
// req_stall rises while the four-entry result queue holds more than two beats.
// Reset clears counters and the queue; line stores are not cleared.
module grid_local_peak_detect_core #(
   parameter int MAX_COLUMNS  = 1024,
   parameter int MAX_ROWS     = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_WIDTH-1:0]              req_sample_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_report_kind,
   output logic [glpd_pkg::ROW_W-1:0]           rsp_peak_row,
   output logic [glpd_pkg::COL_W-1:0]           rsp_peak_column,
   output logic [glpd_pkg::VALUE_W-1:0]         rsp_peak_value,
   output logic [glpd_pkg::TOTAL_W-1:0]         rsp_peak_total,
   output logic                                 rsp_last_of_grid,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [glpd_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [glpd_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [glpd_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import glpd_pkg::*;

   cfg_type         cfg;
   result_push_type push;
   rsp_beat_type    head;
   logic            accept, almost_full;

   assign req_stall = reset | almost_full;
   assign accept    = req_valid & ~req_stall;

   glpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   glpd_window #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .MAX_ROWS     (MAX_ROWS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .accept (accept),
      .sample (req_sample_value),
      .push   (push)
   );

   glpd_result_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .pop         (~rsp_stall),
      .out_valid   (rsp_valid),
      .out_beat    (head),
      .almost_full (almost_full)
   );

   assign rsp_report_kind  = head.report_kind;
   assign rsp_peak_row     = head.peak_row;
   assign rsp_peak_column  = head.peak_column;
   assign rsp_peak_value   = head.peak_value;
   assign rsp_peak_total   = head.peak_total;
   assign rsp_last_of_grid = head.last_of_grid;

endmodule

/* rtl/glpd_line_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module glpd_line_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/glpd_csr.sv */
// Configuration registers behind the APB-style port.
module glpd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [glpd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [glpd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [glpd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output glpd_pkg::cfg_type                   cfg
);
   import glpd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type reg_index;
   logic          wr_strobe;

   assign reg_index = csr_index_type'(paddr[CSR_ADDR_W-1]);
   assign wr_strobe = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_index)
            CSR_GRID_COLUMNS: cfg_in.grid_columns = pwdata[CFG_DIM_W-1:0];
            CSR_GRID_ROWS:    cfg_in.grid_rows    = pwdata[CFG_DIM_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_columns <= GRID_COLUMNS_RESET;
         cfg_ff.grid_rows    <= GRID_ROWS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         CSR_GRID_COLUMNS: prdata = CSR_DATA_W'(cfg_ff.grid_columns);
         CSR_GRID_ROWS:    prdata = CSR_DATA_W'(cfg_ff.grid_rows);
         default:          prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

/* rtl/glpd_window.sv */
// Line stores, raster counters and the four-neighbour peak test.
module glpd_window #(
   parameter int MAX_COLUMNS  = 1024,
   parameter int MAX_ROWS     = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  glpd_pkg::cfg_type             cfg,
   input  logic                          accept,
   input  logic [SAMPLE_WIDTH-1:0]       sample,
   output glpd_pkg::result_push_type     push
);
   import glpd_pkg::*;

   localparam int CW     = $clog2(MAX_COLUMNS);
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int C_BITS = $clog2(MAX_COLUMNS + 1);
   localparam int R_BITS = $clog2(MAX_ROWS + 1);
   localparam int MAX_B  = (C_BITS > R_BITS) ? C_BITS : R_BITS;
   localparam int DIM_W  = ((MAX_B > CFG_DIM_W) ? MAX_B : CFG_DIM_W) + 1;

   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [TOTAL_W-1:0] peak_cnt_ff, peak_cnt_in;
   logic signed [SAMPLE_WIDTH-1:0] west_ff, west_in;

   logic [CW-1:0]      east_addr;
   logic [SAMPLE_WIDTH-1:0] center_raw, north_raw, east_raw;
   logic signed [SAMPLE_WIDTH-1:0] center, north, east, south;

   logic [DIM_W-1:0]   cfg_cols, cfg_rows, cols, rows, col_ext, row_ext;
   logic               in_interior, is_peak, row_end, grid_end;
   logic [TOTAL_W-1:0] total;
   logic [31:0]        row_wide, col_wide;
   logic signed [31:0] center_wide;

   // Clamp dimensions.
   assign cfg_cols = DIM_W'(cfg.grid_columns);
   assign cfg_rows = DIM_W'(cfg.grid_rows);

   always_comb begin
      if (cfg_cols < DIM_W'(MIN_DIM)) begin
         cols = DIM_W'(MIN_DIM);
      end else if (cfg_cols > DIM_W'(MAX_COLUMNS)) begin
         cols = DIM_W'(MAX_COLUMNS);
      end else begin
         cols = cfg_cols;
      end
      if (cfg_rows < DIM_W'(MIN_DIM)) begin
         rows = DIM_W'(MIN_DIM);
      end else if (cfg_rows > DIM_W'(MAX_ROWS)) begin
         rows = DIM_W'(MAX_ROWS);
      end else begin
         rows = cfg_rows;
      end
   end

   assign col_ext = DIM_W'(col_ff);
   assign row_ext = DIM_W'(row_ff);

   assign center = center_raw;
   assign north  = north_raw;
   assign east   = east_raw;
   assign south  = sample;

   assign in_interior = (row_ff >= RW'(2)) && (col_ff >= CW'(1))
                        && (col_ext + DIM_W'(2) <= cols);
   assign is_peak = accept && in_interior && (center > north) && (center > south)
                    && (center > east) && (center > west_ff);

   assign row_end  = (col_ext + DIM_W'(1)) >= cols;
   assign grid_end = row_end && ((row_ext + DIM_W'(1)) >= rows);

   assign total = (is_peak && (peak_cnt_ff != PEAK_TOTAL_MAX))
                  ? peak_cnt_ff + TOTAL_W'(1) : peak_cnt_ff;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      peak_cnt_in = peak_cnt_ff;
      west_in     = west_ff;
      if (accept) begin
         west_in     = center;
         peak_cnt_in = total;
         if (row_end) begin
            col_in = '0;
            if (grid_end) begin
               row_in      = '0;
               peak_cnt_in = '0;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         peak_cnt_ff <= '0;
         west_ff     <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         peak_cnt_ff <= peak_cnt_in;
         west_ff     <= west_in;
      end
   end

   // Prefetch the next column and its east neighbour so read data is ready at the next beat.
   assign east_addr = col_in + CW'(1);

   glpd_line_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_COLUMNS)) u_upper (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (center_raw),
      .rd_addr (col_in),
      .rd_data (north_raw)
   );

   glpd_line_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_COLUMNS)) u_middle_center (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (sample),
      .rd_addr (col_in),
      .rd_data (center_raw)
   );

   glpd_line_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_COLUMNS)) u_middle_east (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (sample),
      .rd_addr (east_addr),
      .rd_data (east_raw)
   );

   assign row_wide    = 32'(row_ff) - 32'd1;
   assign col_wide    = 32'(col_ff);
   assign center_wide = 32'(center);

   always_comb begin
      push.peak_valid         = is_peak;
      push.peak.report_kind   = REPORT_PEAK;
      push.peak.peak_row      = row_wide[ROW_W-1:0];
      push.peak.peak_column   = col_wide[COL_W-1:0];
      push.peak.peak_value    = center_wide[VALUE_W-1:0];
      push.peak.peak_total    = '0;
      push.peak.last_of_grid  = 1'b0;
      push.count_valid        = accept && grid_end;
      push.count.report_kind  = REPORT_COUNT;
      push.count.peak_row     = '0;
      push.count.peak_column  = '0;
      push.count.peak_value   = '0;
      push.count.peak_total   = total;
      push.count.last_of_grid = 1'b1;
   end

endmodule

/* rtl/glpd_result_fifo.sv */
// Small result queue taking up to two beats per cycle.
module glpd_result_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  glpd_pkg::result_push_type     push,
   input  logic                          pop,
   output logic                          out_valid,
   output glpd_pkg::rsp_beat_type        out_beat,
   output logic                          almost_full
);
   import glpd_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_beat_type     q_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             first_valid, second_valid, do_pop;
   rsp_beat_type     first_beat;
   logic [1:0]       n_push;

   assign first_valid  = push.peak_valid | push.count_valid;
   assign second_valid = push.peak_valid & push.count_valid;
   assign first_beat   = push.peak_valid ? push.peak : push.count;
   assign wr_next      = wr_ptr_ff + PTR_W'(1);
   assign n_push       = {1'b0, first_valid} + {1'b0, second_valid};
   assign do_pop       = pop & (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(n_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (first_valid) begin
         q_ff[wr_ptr_ff] <= first_beat;
      end
      if (second_valid) begin
         q_ff[wr_next] <= push.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign out_valid   = (count_ff != '0);
   assign out_beat    = q_ff[rd_ptr_ff];
   assign almost_full = (count_ff > CNT_W'(RSP_DEPTH - 2));

endmodule
